// File: rtl/core/mpd_pkg.sv
// mpd_pkg: shared types, codes and the letter table of the Morse pulse decoder.
// No dependencies; imported by the interfaces file and morse_pulse_decoder.
`default_nettype none

package mpd_pkg;

    localparam int MAX_SYMBOLS = 4;
    localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int TIME_W      = 16;
    localparam int LETTER_W    = 7;
    localparam int NUM_LETTERS = 26;

    localparam logic [TIME_W-1:0] LONG_PULSE    = 16'd65000;
    localparam logic [TIME_W-1:0] TIME_MAX      = 16'hFFFF;
    localparam logic [TIME_W-1:0] NOISE_RESET   = 16'd1875;
    localparam logic [TIME_W-1:0] DOT_RESET     = 16'd12500;
    localparam logic [TIME_W-1:0] DASH_RESET    = 16'd25000;

    localparam logic [LETTER_W-1:0] CHAR_A    = 7'h41;
    localparam logic [LETTER_W-1:0] CHAR_BANG = 7'h21;
    localparam logic [LETTER_W-1:0] CHAR_NONE = 7'h00;

    // input operation codes
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOT_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NOISE  = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_DASH   = 2'd2,
        KIND_LETTER = 2'd3
    } symbol_kind_t;

    typedef struct packed {
        logic [COUNT_W-1:0]     len;
        logic [MAX_SYMBOLS-1:0] bits;
    } morse_pat_t;

    // bit i set means symbol i is a dash; entry i is letter 'A' + i
    localparam morse_pat_t LETTER_PATS [NUM_LETTERS] = '{
        '{3'd2, 4'd2},  '{3'd4, 4'd1},  '{3'd4, 4'd5},  '{3'd3, 4'd1},
        '{3'd1, 4'd0},  '{3'd4, 4'd4},  '{3'd3, 4'd3},  '{3'd4, 4'd0},
        '{3'd2, 4'd0},  '{3'd4, 4'd14}, '{3'd3, 4'd5},  '{3'd4, 4'd2},
        '{3'd2, 4'd3},  '{3'd2, 4'd1},  '{3'd3, 4'd7},  '{3'd4, 4'd6},
        '{3'd4, 4'd11}, '{3'd3, 4'd2},  '{3'd3, 4'd0},  '{3'd1, 4'd1},
        '{3'd3, 4'd4},  '{3'd4, 4'd8},  '{3'd3, 4'd6},  '{3'd4, 4'd9},
        '{3'd4, 4'd13}, '{3'd4, 4'd3}
    };

    // Match a stored pattern against A..Z; '!' when nothing matches.
    function automatic logic [LETTER_W-1:0] lookup_letter(
        input logic [COUNT_W-1:0]     len,
        input logic [MAX_SYMBOLS-1:0] bits
    );
        logic [LETTER_W-1:0] result;
        result = CHAR_BANG;
        for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
            if (LETTER_PATS[i].len == len && LETTER_PATS[i].bits == bits) begin
                result = CHAR_A + LETTER_W'(i);
            end
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mpd_if.sv
// mpd_if: valid/ready channel interfaces for timer events and decoded symbols.
// Depends on mpd_pkg for field widths.
`default_nettype none

interface mpd_event_if import mpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] capture_time;

    modport source (output valid, output op, output capture_time, input ready);
    modport sink   (input valid, input op, input capture_time, output ready);
endinterface

interface mpd_symbol_if import mpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          symbol_kind;
    logic [LETTER_W-1:0] letter;
    logic [TIME_W-1:0]   pulse_ticks;

    modport source (output valid, output symbol_kind, output letter, output pulse_ticks,
                    input ready);
    modport sink   (input valid, input symbol_kind, input letter, input pulse_ticks,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/morse_pulse_decoder.sv
// morse_pulse_decoder: decodes Morse letters from timer overflow ticks and edge captures.
// Depends on mpd_pkg and the channel interfaces in mpd_if.sv.
//
// Usage:
//   events  : one word per timer event; op = 1 is an overflow tick, op = 0 an edge
//             capture carrying capture_time. Captures alternate press start / press end.
//   symbols : one word per press end: symbol_kind (noise, dot, dash, letter ended),
//             letter ('A'..'Z' or '!' on letter ended, else 0) and pulse_ticks.
//   cfg     : cfg_write, cfg_index, cfg_data set noise_limit (0), dot_limit (1) and
//             dash_limit (2); write them only while no event is in flight.
// Timing: an event is captured in an input register, decoded when the decode stage
//   advances by the pulse measure, classifier and letter table, and its word is loaded
//   into the output register at the end of that cycle, which drives symbols.valid.
//   Throughput is one event per cycle unless the output stalls, set by the single decode stage.
// Stall: while symbols.ready is low the output register holds its word and the
//   decode stage holds; the input register still takes one more event.
// Reset: thresholds return to 1875 / 12500 / 25000, the decoder waits for a press
//   start, the symbol store is empty and both channels are empty.
`default_nettype none

module morse_pulse_decoder import mpd_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mpd_event_if.sink                   events,
    mpd_symbol_if.source                symbols,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]      cfg_data
);

    // configuration
    logic [TIME_W-1:0] noise_limit_reg;
    logic [TIME_W-1:0] dot_limit_reg;
    logic [TIME_W-1:0] dash_limit_reg;

    // input register
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [TIME_W-1:0] in_time_reg;

    // decoder state
    logic                   expect_start_reg, expect_start_next;
    logic [TIME_W-1:0]      start_time_reg, start_time_next;
    logic [1:0]             wrap_count_reg, wrap_count_next;
    logic [MAX_SYMBOLS-1:0] store_reg, store_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   too_many_reg, too_many_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg;
    logic [LETTER_W-1:0] out_letter_reg;
    logic [TIME_W-1:0]   out_ticks_reg;

    logic                advance;
    logic                decode;
    logic                press_end;
    logic [TIME_W-1:0]   rest;
    logic [TIME_W:0]     wrap_sum;
    logic [TIME_W-1:0]   pulse;
    symbol_kind_t        kind;
    logic [LETTER_W-1:0] letter;

    // handshake: the decode stage moves when the output register is free
    assign advance       = !out_valid_reg || symbols.ready;
    assign events.ready  = !in_valid_reg || advance;
    assign decode        = in_valid_reg && advance;
    assign press_end     = (in_op_reg == OP_CAPTURE) && !expect_start_reg;

    // write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_limit_reg <= NOISE_RESET;
            dot_limit_reg   <= DOT_RESET;
            dash_limit_reg  <= DASH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NOISE_LIMIT: noise_limit_reg <= cfg_data;
                CFG_DOT_LIMIT:   dot_limit_reg   <= cfg_data;
                CFG_DASH_LIMIT:  dash_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // capture the incoming event word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            in_valid_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            in_op_reg   <= events.op;
            in_time_reg <= events.capture_time;
        end
    end

    // measure the pulse: direct difference, single-wrap sum, or long
    always_comb
    begin
        rest     = ~start_time_reg;
        wrap_sum = {1'b0, rest} + {1'b0, in_time_reg} + 17'd1;
        pulse    = LONG_PULSE;
        if (wrap_count_reg == 2'd0)
        begin
            if (in_time_reg >= start_time_reg)
            begin
                pulse = in_time_reg - start_time_reg;
            end
        end
        else if (wrap_count_reg == 2'd1)
        begin
            if (rest < dash_limit_reg && in_time_reg < dash_limit_reg)
            begin
                pulse = wrap_sum[TIME_W] ? TIME_MAX : wrap_sum[TIME_W-1:0];
            end
        end
    end

    // classify against the thresholds in priority order
    always_comb
    begin
        if (pulse < noise_limit_reg)
        begin
            kind = KIND_NOISE;
        end
        else if (pulse < dot_limit_reg)
        begin
            kind = KIND_DOT;
        end
        else if (pulse < dash_limit_reg)
        begin
            kind = KIND_DASH;
        end
        else
        begin
            kind = KIND_LETTER;
        end
    end

    // look up the stored symbols; cleared slots above the count read as zero
    always_comb
    begin
        if (too_many_reg || count_reg == '0)
        begin
            letter = CHAR_BANG;
        end
        else
        begin
            letter = lookup_letter(count_reg, store_reg);
        end
    end

    // advance decoder state for one event
    always_comb
    begin
        expect_start_next = expect_start_reg;
        start_time_next   = start_time_reg;
        wrap_count_next   = wrap_count_reg;
        store_next        = store_reg;
        count_next        = count_reg;
        too_many_next     = too_many_reg;
        out_valid_next    = out_valid_reg && !symbols.ready;
        if (decode)
        begin
            out_valid_next = press_end;
            if (in_op_reg == OP_TICK)
            begin
                if (wrap_count_reg != 2'd2)
                begin
                    wrap_count_next = wrap_count_reg + 2'd1;
                end
            end
            else if (expect_start_reg)
            begin
                start_time_next   = in_time_reg;
                wrap_count_next   = 2'd0;
                expect_start_next = 1'b0;
            end
            else
            begin
                expect_start_next = 1'b1;
                case (kind) inside
                    KIND_DOT, KIND_DASH:
                    begin
                        if (count_reg < COUNT_W'(MAX_SYMBOLS))
                        begin
                            store_next[count_reg[$clog2(MAX_SYMBOLS)-1:0]] =
                                (kind == KIND_DASH);
                            count_next = count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            too_many_next = 1'b1;
                        end
                    end
                    KIND_LETTER:
                    begin
                        store_next    = '0;
                        count_next    = '0;
                        too_many_next = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_start_reg <= 1'b1;
            start_time_reg   <= '0;
            wrap_count_reg   <= 2'd0;
            store_reg        <= '0;
            count_reg        <= '0;
            too_many_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            expect_start_reg <= expect_start_next;
            start_time_reg   <= start_time_next;
            wrap_count_reg   <= wrap_count_next;
            store_reg        <= store_next;
            count_reg        <= count_next;
            too_many_reg     <= too_many_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // load the result word at a press end
    always_ff @(posedge clk)
    begin
        if (decode && press_end)
        begin
            out_kind_reg   <= kind;
            out_letter_reg <= (kind == KIND_LETTER) ? letter : CHAR_NONE;
            out_ticks_reg  <= pulse;
        end
    end

    assign symbols.valid       = out_valid_reg;
    assign symbols.symbol_kind = out_kind_reg;
    assign symbols.letter      = out_letter_reg;
    assign symbols.pulse_ticks = out_ticks_reg;

    // store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond store depth");

    // overflow flag only once the store is full
    assert property (@(posedge clk) disable iff (!rst_n)
        too_many_reg |-> count_reg == COUNT_W'(MAX_SYMBOLS))
        else $error("overflow flag with store not full");

    // only a letter-ended word carries a character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != KIND_LETTER) |-> out_letter_reg == CHAR_NONE)
        else $error("character on a non-letter word");

    // a space decoded leaves the store empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (decode && press_end && kind == KIND_LETTER) |=> (count_reg == '0 && !too_many_reg))
        else $error("store not cleared after letter end");

    // input stalls only with both registers full
    assert property (@(posedge clk) disable iff (!rst_n)
        !events.ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free register");

endmodule

`default_nettype wire

// File: dv/morse_pulse_decoder_checker.sv
// morse_pulse_decoder_checker: predicts the symbol words of the Morse pulse decoder and
// compares each accepted word with its prediction. Depends on mpd_pkg; the testbench top
// instantiates it beside the block and reads back the mismatch count.
module morse_pulse_decoder_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ev_valid,
    input  logic                                ev_ready,
    input  logic                                ev_op,
    input  logic [mpd_pkg::TIME_W-1:0]          ev_time,
    input  logic                                sy_valid,
    input  logic                                sy_ready,
    input  logic [1:0]                          sy_kind,
    input  logic [mpd_pkg::LETTER_W-1:0]        sy_letter,
    input  logic [mpd_pkg::TIME_W-1:0]          sy_ticks,
    input  logic                                cfg_write,
    input  logic [mpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpd_pkg::TIME_W-1:0]          cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpd_pkg::*;

    typedef struct {
        symbol_kind_t        kind;
        logic [LETTER_W-1:0] letter;
        logic [TIME_W-1:0]   ticks;
    } symbol_word_t;

    // Morse codes of A..Z, dot first
    string morse_codes [NUM_LETTERS] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };

    logic [TIME_W-1:0] noise_lim;
    logic [TIME_W-1:0] dot_lim;
    logic [TIME_W-1:0] dash_lim;
    bit                awaiting_start;
    logic [TIME_W-1:0] start_stamp;
    int unsigned       wraps;
    string             held_code;
    bit                overfull;
    symbol_word_t      expected_words [$];
    int                mismatches = 0;
    int                outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 25)
        begin
            $display("[%0t] symbol check: %s", $time, what);
        end
    endtask

    // Press length from the stored start, the wrap count and the end stamp
    function automatic logic [TIME_W-1:0] press_length(logic [TIME_W-1:0] stamp);
        int unsigned tail;
        int unsigned total;
        if (wraps >= 2)
        begin
            return LONG_PULSE;
        end
        if (wraps == 0)
        begin
            return (stamp < start_stamp) ? LONG_PULSE : TIME_W'(stamp - start_stamp);
        end
        tail = 65535 - int'(start_stamp);
        if (tail < dash_lim && stamp < dash_lim)
        begin
            total = 65536 - int'(start_stamp) + int'(stamp);
            return (total > 65535) ? TIME_MAX : TIME_W'(total);
        end
        return LONG_PULSE;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of_code();
        if (overfull || held_code.len() == 0)
        begin
            return CHAR_BANG;
        end
        foreach (morse_codes[i])
        begin
            if (morse_codes[i] == held_code)
            begin
                return CHAR_A + LETTER_W'(i);
            end
        end
        return CHAR_BANG;
    endfunction

    // Advance the decoder state by one event word; queue the symbol word it causes
    task automatic take_event(logic op, logic [TIME_W-1:0] stamp);
        symbol_word_t word;
        string        mark;
        if (op == OP_TICK)
        begin
            if (wraps < 2)
            begin
                wraps++;
            end
            return;
        end
        if (awaiting_start)
        begin
            start_stamp    = stamp;
            wraps          = 0;
            awaiting_start = 1'b0;
            return;
        end
        awaiting_start = 1'b1;
        word.ticks  = press_length(stamp);
        word.letter = CHAR_NONE;
        if (word.ticks < noise_lim)
        begin
            word.kind = KIND_NOISE;
        end
        else if (word.ticks < dot_lim || word.ticks < dash_lim)
        begin
            word.kind = (word.ticks < dot_lim) ? KIND_DOT : KIND_DASH;
            mark = (word.kind == KIND_DASH) ? "-" : ".";
            if (held_code.len() < MAX_SYMBOLS)
            begin
                held_code = {held_code, mark};
            end
            else
            begin
                overfull = 1'b1;
            end
        end
        else
        begin
            word.kind   = KIND_LETTER;
            word.letter = letter_of_code();
            held_code   = "";
            overfull    = 1'b0;
        end
        expected_words.push_back(word);
    endtask

    // Compare one accepted symbol word with the oldest prediction
    task automatic check_word();
        symbol_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word kind=%0d letter=%0h ticks=%0d",
                                      sy_kind, sy_letter, sy_ticks));
            return;
        end
        want = expected_words.pop_front();
        if (sy_kind !== want.kind)
        begin
            report_mismatch($sformatf("symbol_kind %0d, want %0d (ticks %0d)",
                                      sy_kind, want.kind, want.ticks));
        end
        if (sy_letter !== want.letter)
        begin
            report_mismatch($sformatf("letter %0h, want %0h", sy_letter, want.letter));
        end
        if (sy_ticks !== want.ticks)
        begin
            report_mismatch($sformatf("pulse_ticks %0d, want %0d", sy_ticks, want.ticks));
        end
    endtask

    // Watch the channels and the config port at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_lim      = NOISE_RESET;
            dot_lim        = DOT_RESET;
            dash_lim       = DASH_RESET;
            awaiting_start = 1'b1;
            start_stamp    = '0;
            wraps          = 0;
            held_code      = "";
            overfull       = 1'b0;
            expected_words.delete();
        end
        else
        begin
            if (sy_valid && sy_ready)
            begin
                check_word();
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NOISE_LIMIT: noise_lim = cfg_data;
                    CFG_DOT_LIMIT:   dot_lim   = cfg_data;
                    CFG_DASH_LIMIT:  dash_lim  = cfg_data;
                    default: ;
                endcase
            end
            if (ev_valid && ev_ready)
            begin
                take_event(ev_op, ev_time);
            end
        end
        outstanding = expected_words.size();
    end

endmodule

// File: dv/morse_pulse_decoder_tb.sv
// morse_pulse_decoder_tb: drives timer events and limit writes into morse_pulse_decoder,
// stalls the symbol channel at random and gives the verdict.
// Depends on mpd_pkg, the channel interfaces and morse_pulse_decoder_checker.
module morse_pulse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 107;
    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_WAIT  = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TIME_W-1:0]      cfg_data;
    int                     fail_count;
    int                     pending;

    mpd_event_if  events ();
    mpd_symbol_if symbols ();

    int words_sent = 0;
    int send_calm  = 0;
    int recv_calm  = 0;
    int lim_noise  = NOISE_RESET;
    int lim_dot    = DOT_RESET;
    int lim_dash   = DASH_RESET;
    int cycle_count = 0;

    // noise, dot and dash limits per phase after the reset phase
    int limit_sets [6][3] = '{
        '{0, 0, 0},
        '{65535, 65535, 65535},
        '{5000, 2000, 9000},
        '{100, 1000, 3000},
        '{0, 40000, 65535},
        '{1875, 12500, 25000}
    };

    morse_pulse_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .symbols   (symbols),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    morse_pulse_decoder_checker symbol_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev_valid   (events.valid),
        .ev_ready   (events.ready),
        .ev_op      (events.op),
        .ev_time    (events.capture_time),
        .sy_valid   (symbols.valid),
        .sy_ready   (symbols.ready),
        .sy_kind    (symbols.symbol_kind),
        .sy_letter  (symbols.letter),
        .sy_ticks   (symbols.pulse_ticks),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle cycles before the next word; calm stretches draw no idling at all
    function automatic int idle_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(20, 60);
        end
        return $urandom_range(0, 17);
    endfunction

    // Offer one event word and hold it until the block takes it
    task automatic send_event(logic op, logic [TIME_W-1:0] stamp);
        int gap;
        gap = idle_gap(send_calm);
        if (gap > 0)
        begin
            events.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        events.valid        <= 1'b1;
        events.op           <= op;
        events.capture_time <= stamp;
        do
            @(posedge clk);
        while (!events.ready);
        words_sent++;
    endtask

    task automatic capture(int unsigned stamp);
        send_event(OP_CAPTURE, TIME_W'(stamp));
    endtask

    task automatic tick();
        send_event(OP_TICK, TIME_W'($urandom));
    endtask

    // One press of the given length, sometimes across a timer wrap
    task automatic press(int unsigned length);
        int unsigned first;
        if (length > 0 && $urandom_range(0, 3) == 0)
        begin
            first = $urandom_range(65535, 65536 - length);
            capture(first);
            tick();
            capture(first + length - 65536);
        end
        else
        begin
            // stray wrap before the start; the start clears it
            if ($urandom_range(0, 7) == 0)
            begin
                tick();
            end
            first = $urandom_range(0, 65535 - length);
            capture(first);
            capture(first + length);
        end
    endtask

    // Length that falls in the band of one symbol kind under the current limits
    function automatic int unsigned pulse_for(symbol_kind_t kind);
        int lo;
        int hi;
        case (kind)
            KIND_NOISE:
            begin
                lo = 0;
                hi = lim_noise - 1;
            end
            KIND_DOT:
            begin
                lo = lim_noise;
                hi = lim_dot - 1;
            end
            KIND_DASH:
            begin
                lo = (lim_noise > lim_dot) ? lim_noise : lim_dot;
                hi = lim_dash - 1;
            end
            default:
            begin
                lo = (lim_noise > lim_dot) ? lim_noise : lim_dot;
                lo = (lo > lim_dash) ? lo : lim_dash;
                hi = 65535;
            end
        endcase
        if (lo > hi)
        begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(hi, lo);
    endfunction

    // A run of dots and dashes closed by a space, with noise mixed in
    task automatic send_letter();
        int count;
        count = $urandom_range(0, 5);
        repeat (count)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                press(pulse_for(KIND_NOISE));
            end
            press(pulse_for($urandom_range(0, 1) ? KIND_DASH : KIND_DOT));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            // too long: two wraps inside the press
            capture($urandom);
            tick();
            tick();
            capture($urandom);
        end
        else
        begin
            press(pulse_for(KIND_LETTER));
        end
    endtask

    task automatic write_limits(int noise, int dot, int dash);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NOISE_LIMIT;
        cfg_data  <= TIME_W'(noise);
        @(posedge clk);
        cfg_index <= CFG_DOT_LIMIT;
        cfg_data  <= TIME_W'(dot);
        @(posedge clk);
        cfg_index <= CFG_DASH_LIMIT;
        cfg_data  <= TIME_W'(dash);
        @(posedge clk);
        cfg_write <= 1'b0;
        lim_noise = noise;
        lim_dot   = dot;
        lim_dash  = dash;
    endtask

    // Stop sending and wait until every predicted word has come out
    task automatic settle();
        events.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Receiver: random stalls per word, long holds now and then
    initial
    begin
        int taken;
        int stall_left;
        taken      = 0;
        stall_left = 0;
        symbols.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (symbols.valid && symbols.ready)
            begin
                taken++;
                stall_left = (taken % 300 == 40) ? LONG_HOLD : idle_gap(recv_calm);
            end
            if (stall_left > 0)
            begin
                symbols.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                symbols.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** morse_pulse_decoder: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int phase_end;
        int pick;
        events.valid        <= 1'b0;
        events.op           <= OP_CAPTURE;
        events.capture_time <= '0;
        cfg_write           <= 1'b0;
        cfg_index           <= CFG_NOISE_LIMIT;
        cfg_data            <= '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero-length press is noise
        capture(0);
        capture(0);
        // dot, then a full-range space gives E
        capture(100);
        capture(5100);
        capture(0);
        capture(65535);
        // end before start without a wrap is too long; empty store gives '!'
        capture(60000);
        capture(10);
        // dash across one wrap, then two wraps make a space: T
        capture(60000);
        tick();
        capture(15000);
        capture(5);
        tick();
        tick();
        capture(5);
        // wrap with a start too far from the top is too long
        tick();
        capture(1000);
        tick();
        capture(1000);
        // lengths exactly on the limits: dot, dash, space gives A
        capture(200);
        capture(200 + NOISE_RESET);
        capture(300);
        capture(300 + DOT_RESET);
        capture(400);
        capture(400 + DASH_RESET);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                write_limits(limit_sets[p-1][0], limit_sets[p-1][1], limit_sets[p-1][2]);
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    send_letter();
                end
                else if (pick == 8)
                begin
                    press($urandom_range(0, 65535));
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                        send_event(1'($urandom_range(0, 1)), TIME_W'($urandom));
                end
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** morse_pulse_decoder: PASSED **");
        end
        else
        begin
            $display("** morse_pulse_decoder: FAILED **");
        end
        $finish;
    end

endmodule
